// File: sv/binary_to_roman_numeral_assert.svh
// Assertion macros used by the checker of the Roman numeral converter.
`ifndef BINARY_TO_ROMAN_NUMERAL_ASSERT_SVH
`define BINARY_TO_ROMAN_NUMERAL_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define BTRN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define BTRN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/btrn_pkg.sv
// Types, letter codes and spelling functions of the Roman numeral converter.
package btrn_pkg;

  typedef logic [3:0] digit_t;
  typedef digit_t [3:0] digits_t;

  typedef enum logic [1:0] {
    SHAPE_ONE,
    SHAPE_FIVE,
    SHAPE_TEN
  } shape_t;

  localparam logic [6:0] LETTER_I = 7'h49;
  localparam logic [6:0] LETTER_V = 7'h56;
  localparam logic [6:0] LETTER_X = 7'h58;
  localparam logic [6:0] LETTER_L = 7'h4C;
  localparam logic [6:0] LETTER_C = 7'h43;
  localparam logic [6:0] LETTER_D = 7'h44;
  localparam logic [6:0] LETTER_M = 7'h4D;
  localparam logic [6:0] LETTER_NONE = 7'h00;

  localparam logic [11:0] VALUE_LIMIT = 12'd4000;

  function automatic logic [2:0] digit_len(input digit_t d);
    logic [2:0] n;
    case (d)
      4'd1, 4'd5: n = 3'd1;
      4'd2, 4'd4, 4'd6, 4'd9: n = 3'd2;
      4'd3, 4'd7: n = 3'd3;
      4'd8: n = 3'd4;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic shape_t digit_shape(input digit_t d, input logic [1:0] idx);
    shape_t s;
    case (d)
      4'd4: s = (idx == 2'd0) ? SHAPE_ONE : SHAPE_FIVE;
      4'd5: s = SHAPE_FIVE;
      4'd6, 4'd7, 4'd8: s = (idx == 2'd0) ? SHAPE_FIVE : SHAPE_ONE;
      4'd9: s = (idx == 2'd0) ? SHAPE_ONE : SHAPE_TEN;
      default: s = SHAPE_ONE;
    endcase
    return s;
  endfunction

  function automatic logic [6:0] letter(input logic [1:0] pos, input shape_t s);
    logic [6:0] c;
    case (pos)
      2'd0: begin
        case (s)
          SHAPE_ONE: c = LETTER_I;
          SHAPE_FIVE: c = LETTER_V;
          default: c = LETTER_X;
        endcase
      end
      2'd1: begin
        case (s)
          SHAPE_ONE: c = LETTER_X;
          SHAPE_FIVE: c = LETTER_L;
          default: c = LETTER_C;
        endcase
      end
      2'd2: begin
        case (s)
          SHAPE_ONE: c = LETTER_C;
          SHAPE_FIVE: c = LETTER_D;
          default: c = LETTER_M;
        endcase
      end
      default: c = LETTER_M;
    endcase
    return c;
  endfunction

endpackage

// File: sv/binary_to_roman_numeral.sv
// Binary to Roman numeral converter: one ASCII letter per result request.
// The request is registered, split into digits held in dig_r, and each letter is registered.
// Throughput: one letter per cycle unless out_ready stalls it; a value gives as many letters as
// its numeral has (1 to 15), or one when out of range; the single letter emitter sets this.
// Reset clears the valid and busy flags; the data registers are not reset.
module binary_to_roman_numeral
  import btrn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_symbol,
  output logic        out_out_of_range,
  output logic        out_last_symbol
);

  logic        vld_r, vld_nxt;
  logic [11:0] val_r, val_nxt;
  logic        busy_r, busy_nxt;
  digits_t     dig_r, dig_nxt;
  logic        oor_r, oor_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [6:0]  out_symbol_r, out_symbol_nxt;
  logic        out_oor_r, out_oor_nxt;
  logic        out_last_r, out_last_nxt;

  digits_t     new_digits;
  logic        new_oor;
  logic [1:0]  start_pos;
  logic        emit;
  logic        dig_load;
  logic        more;
  logic        found;
  logic [1:0]  low_pos;
  logic        last;
  logic [6:0]  sym;

  btrn_digits u_digits (
    .value        (val_r),
    .digits       (new_digits),
    .out_of_range (new_oor)
  );

  always_comb begin
    start_pos = 2'd0;
    for (int p = 0; p < 4; p++) begin
      if (new_digits[p] != 4'd0) begin
        start_pos = 2'(p);
      end
    end
    low_pos = 2'd0;
    found = 1'b0;
    for (int p = 0; p < 4; p++) begin
      if ((2'(p) < pos_r) && (dig_r[p] != 4'd0)) begin
        low_pos = 2'(p);
        found = 1'b1;
      end
    end
  end

  assign more     = ({1'b0, idx_r} + 3'd1) < digit_len(dig_r[pos_r]);
  assign last     = oor_r || (!more && !found);
  assign sym      = oor_r ? LETTER_NONE : letter(pos_r, digit_shape(dig_r[pos_r], idx_r));
  assign emit     = busy_r && (!out_valid_r || out_ready);
  assign dig_load = vld_r && (!busy_r || (emit && last));
  assign in_ready = !vld_r || dig_load;

  always_comb begin
    vld_nxt        = vld_r;
    val_nxt        = val_r;
    busy_nxt       = busy_r;
    dig_nxt        = dig_r;
    oor_nxt        = oor_r;
    pos_nxt        = pos_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = out_valid_r;
    out_symbol_nxt = out_symbol_r;
    out_oor_nxt    = out_oor_r;
    out_last_nxt   = out_last_r;

    if (in_ready) begin
      vld_nxt = in_valid;
      if (in_valid) begin
        val_nxt = in_value;
      end
    end

    if (emit) begin
      out_valid_nxt  = 1'b1;
      out_symbol_nxt = sym;
      out_oor_nxt    = oor_r;
      out_last_nxt   = last;
      if (last) begin
        busy_nxt = 1'b0;
      end else if (more) begin
        idx_nxt = idx_r + 2'd1;
      end else begin
        pos_nxt = low_pos;
        idx_nxt = 2'd0;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (dig_load) begin
      busy_nxt = 1'b1;
      dig_nxt  = new_digits;
      oor_nxt  = new_oor;
      pos_nxt  = start_pos;
      idx_nxt  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= 1'b0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r        <= val_nxt;
    dig_r        <= dig_nxt;
    oor_r        <= oor_nxt;
    pos_r        <= pos_nxt;
    idx_r        <= idx_nxt;
    out_symbol_r <= out_symbol_nxt;
    out_oor_r    <= out_oor_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_symbol       = out_symbol_r;
  assign out_out_of_range = out_oor_r;
  assign out_last_symbol  = out_last_r;

endmodule

// File: sv/btrn_digits.sv
// Splits a 12-bit value into decimal digits and flags values outside 1 to 3999.
module btrn_digits
  import btrn_pkg::*;
(
  input  logic [11:0] value,
  output digits_t     digits,
  output logic        out_of_range
);

  always_comb begin
    logic [11:0] r1;
    logic [11:0] r2;
    logic [11:0] r3;
    digit_t thou;
    digit_t hund;
    digit_t tens;
    thou = 4'd0;
    r1 = value;
    for (int k = 1; k <= 3; k++) begin
      if (value >= 12'(k * 1000)) begin
        thou = 4'(k);
        r1 = value - 12'(k * 1000);
      end
    end
    hund = 4'd0;
    r2 = r1;
    for (int k = 1; k <= 9; k++) begin
      if (r1 >= 12'(k * 100)) begin
        hund = 4'(k);
        r2 = r1 - 12'(k * 100);
      end
    end
    tens = 4'd0;
    r3 = r2;
    for (int k = 1; k <= 9; k++) begin
      if (r2 >= 12'(k * 10)) begin
        tens = 4'(k);
        r3 = r2 - 12'(k * 10);
      end
    end
    digits[3] = thou;
    digits[2] = hund;
    digits[1] = tens;
    digits[0] = r3[3:0];
  end

  assign out_of_range = (value == 12'd0) || (value >= VALUE_LIMIT);

endmodule

// File: sv/btrn_checker.sv
// Port-level checker for the Roman numeral converter and its bind statement.
`include "binary_to_roman_numeral_assert.svh"

module btrn_checker
  import btrn_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [11:0] in_value,
  input logic        out_valid,
  input logic        out_ready,
  input logic [6:0]  out_symbol,
  input logic        out_out_of_range,
  input logic        out_last_symbol
);

  logic is_letter;
  logic in_seen;

  assign is_letter = (out_symbol == LETTER_I) || (out_symbol == LETTER_V) ||
                     (out_symbol == LETTER_X) || (out_symbol == LETTER_L) ||
                     (out_symbol == LETTER_C) || (out_symbol == LETTER_D) ||
                     (out_symbol == LETTER_M);
  assign in_seen = in_valid && in_ready && (in_value != 12'd0);

  `BTRN_ASSERT_NOW(a_oor_single, out_valid && out_out_of_range, out_last_symbol && (out_symbol == LETTER_NONE), "Out-of-range request must be a single empty result.")
  `BTRN_ASSERT_NOW(a_letter, out_valid && !out_out_of_range, is_letter, "Valid run carries a non-numeral character.")
  `BTRN_ASSERT_NEXT(a_no_gap, out_valid && out_ready && !out_last_symbol, out_valid, "Gap inside a run of letters.")
  `BTRN_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_symbol) && $stable(out_last_symbol) && $stable(in_seen || !in_seen), "Stalled result changed.")

endmodule

bind binary_to_roman_numeral btrn_checker u_btrn_checker (.*);
